FILE: rtl/lpr_pkg.sv
// shared types and constants of the line pixel rasterizer
// configuration record, queued command record, register indexes
// no dependencies
package lpr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 12;
  localparam int STRIDE_W    = 16;
  localparam int COLOR_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAN_X         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAN_Y         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_PIXELS   = 3'd5;

  localparam logic [DIM_W-1:0]    RESET_WIDTH  = 12'd1366;
  localparam logic [DIM_W-1:0]    RESET_HEIGHT = 12'd700;
  localparam logic [STRIDE_W-1:0] RESET_STRIDE = 16'd5464;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]    screen_width;
    logic [DIM_W-1:0]    screen_height;
    logic [DIM_W-1:0]    pan_x;
    logic [DIM_W-1:0]    pan_y;
    logic [STRIDE_W-1:0] row_stride;
    logic                wide_pixels;
  } cfg_t;

  typedef struct packed {
    logic               is_step;
    logic               major_y;
    logic               minor_down;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage

FILE: rtl/lpr_front.sv
// front end: classifies each beat and sets up a loaded line
// endpoint swap, deltas, slope class, initial decision value
// depends on lpr_pkg
module lpr_front #(
  parameter int COORD_BITS = 12,
  parameter int ERR_W      = COORD_BITS + 3
) (
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green_level,
  input  logic [7:0]                   blue,
  input  logic [7:0]                   alpha,
  output lpr_pkg::cmd_t                cmd,
  output logic [COORD_BITS-1:0]        set_x,
  output logic [COORD_BITS-1:0]        set_y,
  output logic [COORD_BITS-1:0]        set_end,
  output logic [COORD_BITS-1:0]        set_dmaj,
  output logic [COORD_BITS-1:0]        set_dmin,
  output logic [ERR_W-1:0]             set_err
);

  localparam int CW = COORD_BITS;

  logic                swap;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic signed [CW:0]  dx_full, dy_full, ady_full;
  logic [CW-1:0]       dx, ady;
  logic                dy_neg, x_major;
  logic [ERR_W-1:0]    dmin_ext, dmaj_ext;

  always_comb begin
    swap = end_x < start_x;
    x1 = swap ? end_x : start_x;
    y1 = swap ? end_y : start_y;
    x2 = swap ? start_x : end_x;
    y2 = swap ? start_y : end_y;

    dx_full  = {x2[CW-1], x2} - {x1[CW-1], x1};
    dy_full  = {y2[CW-1], y2} - {y1[CW-1], y1};
    dy_neg   = dy_full[CW];
    ady_full = dy_neg ? -dy_full : dy_full;
    dx       = dx_full[CW-1:0];
    ady      = ady_full[CW-1:0];
    x_major  = (dx != '0) && (ady <= dx);

    cmd.is_step    = (kind == lpr_pkg::KIND_STEP);
    cmd.color      = {alpha, red, green_level, blue};
    cmd.major_y    = !x_major;
    cmd.minor_down = dy_neg;

    if (x_major) begin
      set_x    = x1;
      set_y    = y1;
      set_end  = x2;
      set_dmaj = dx;
      set_dmin = ady;
    end else if (!dy_neg) begin
      set_x    = x1;
      set_y    = y1;
      set_end  = y2;
      set_dmaj = ady;
      set_dmin = dx;
    end else begin
      set_x    = x2;
      set_y    = y2;
      set_end  = y1;
      set_dmaj = ady;
      set_dmin = dx;
    end

    dmin_ext = {{(ERR_W-CW){1'b0}}, set_dmin};
    dmaj_ext = {{(ERR_W-CW){1'b0}}, set_dmaj};
    set_err  = {dmin_ext[ERR_W-2:0], 1'b0} - dmaj_ext;
  end

endmodule

FILE: rtl/lpr_queue.sv
// small register queue between front and back end
// independent push and pop, full and empty flags
// no dependencies
module lpr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lpr_back.sv
// back end: line walker with clipping, addressing and color packing
// holds the current line and the output register
// depends on lpr_pkg
module lpr_back #(
  parameter int COORD_BITS = 12,
  parameter int ERR_W      = COORD_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpr_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  lpr_pkg::cmd_t         q_cmd,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic [COORD_BITS-1:0] q_end,
  input  logic [COORD_BITS-1:0] q_dmaj,
  input  logic [COORD_BITS-1:0] q_dmin,
  input  logic [ERR_W-1:0]      q_err,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           byte_offset,
  output logic [31:0]           pixel_word,
  output logic                  visible,
  output logic                  is_last
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = lpr_pkg::DIM_W;
  localparam int CMP_W = ((CW > DW) ? CW : DW) + 1;

  logic [CW-1:0]    cur_x, cur_y, major_end, delta_major, delta_minor;
  logic [ERR_W-1:0] error_term;
  logic             major_y, minor_down, line_active;
  logic [31:0]      line_color;

  logic                    out_free, emit, last, vis;
  logic signed [CMP_W-1:0] cx_ext, cy_ext, w_ext, h_ext;
  logic [DW:0]             xs, ys;
  logic [28:0]             yprod;
  logic [14:0]             xterm;
  logic [31:0]             offset, word, wide_word;
  logic [15:0]             narrow_word;
  logic [CW-1:0]           cur_x_next, cur_y_next, minor_cur, minor_next;
  logic [ERR_W-1:0]        err_next, dmaj_ext, dmin_ext;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = q_valid && (!q_cmd.is_step || !line_active || out_free);
  assign emit     = q_pop && q_cmd.is_step && line_active;

  always_comb begin
    cx_ext = {{(CMP_W-CW){cur_x[CW-1]}}, cur_x};
    cy_ext = {{(CMP_W-CW){cur_y[CW-1]}}, cur_y};
    w_ext  = {{(CMP_W-DW){1'b0}}, cfg.screen_width};
    h_ext  = {{(CMP_W-DW){1'b0}}, cfg.screen_height};
    vis    = !cx_ext[CMP_W-1] && (cx_ext != '0) && (cx_ext <= w_ext) &&
             !cy_ext[CMP_W-1] && (cy_ext != '0) && (cy_ext <= h_ext);

    xs    = {1'b0, cx_ext[DW-1:0]} + {1'b0, cfg.pan_x};
    ys    = {1'b0, cy_ext[DW-1:0]} + {1'b0, cfg.pan_y};
    yprod = {16'b0, ys} * {13'b0, cfg.row_stride};
    xterm = cfg.wide_pixels ? {xs, 2'b00} : {1'b0, xs, 1'b0};
    offset = {3'b0, yprod} + {17'b0, xterm};

    narrow_word = {line_color[20:16], 11'b0} | {3'b0, line_color[15:8], 5'b0} |
                  {8'b0, line_color[7:0]};
    wide_word   = line_color;
    word        = cfg.wide_pixels ? wide_word : {16'b0, narrow_word};

    last = (major_y ? cur_y : cur_x) == major_end;

    // walk one step along the major axis, maybe one along the minor axis
    dmaj_ext  = {{(ERR_W-CW){1'b0}}, delta_major};
    dmin_ext  = {{(ERR_W-CW){1'b0}}, delta_minor};
    minor_cur = major_y ? cur_x : cur_y;
    if (!error_term[ERR_W-1] && (error_term != '0)) begin
      minor_next = minor_down ? minor_cur - 1'b1 : minor_cur + 1'b1;
      err_next   = error_term - {dmaj_ext[ERR_W-2:0], 1'b0} +
                   {dmin_ext[ERR_W-2:0], 1'b0};
    end else begin
      minor_next = minor_cur;
      err_next   = error_term + {dmin_ext[ERR_W-2:0], 1'b0};
    end
    cur_x_next = major_y ? minor_next : cur_x + 1'b1;
    cur_y_next = major_y ? cur_y + 1'b1 : minor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop && !q_cmd.is_step) begin
        line_active <= 1'b1;
      end else if (emit && last) begin
        line_active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_step) begin
      cur_x       <= q_x;
      cur_y       <= q_y;
      major_end   <= q_end;
      delta_major <= q_dmaj;
      delta_minor <= q_dmin;
      error_term  <= q_err;
      major_y     <= q_cmd.major_y;
      minor_down  <= q_cmd.minor_down;
      line_color  <= q_cmd.color;
    end else if (emit && !last) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= err_next;
    end
    if (emit) begin
      byte_offset <= vis ? offset : '0;
      pixel_word  <= vis ? word : '0;
      visible     <= vis;
      is_last     <= last;
    end
  end

endmodule

FILE: rtl/line_pixel_rasterizer.sv
// line pixel rasterizer top level: configuration registers, front end,
// command queue and back end
// depends on lpr_pkg, lpr_front, lpr_queue, lpr_back
//
// A load beat (kind 0) sets up a new line from two endpoints and a color and
// gives no result; each step beat (kind 1) gives the next pixel of the active
// line, with its clip flag, framebuffer byte offset, packed color and a flag
// on the final pixel; a step with no active line gives nothing. The block
// takes one beat per clock while in_stall is low. Each beat is set up in
// the front end in the cycle it is taken and lands in a two-entry queue;
// the back end retires one queue entry per clock unless a step waits on a
// stalled output, and each pixel is registered at the output as its step
// leaves the queue head, in its single walk-and-address stage. Register
// writes take effect at once and should be made with the block idle.
module line_pixel_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [lpr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         end_x,
  input  logic signed [COORD_BITS-1:0]         end_y,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green_level,
  input  logic [7:0]                           blue,
  input  logic [7:0]                           alpha,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          byte_offset,
  output logic [31:0]                          pixel_word,
  output logic                                 visible,
  output logic                                 is_last
);

  localparam int CW      = COORD_BITS;
  localparam int ERR_W   = COORD_BITS + 3;
  localparam int CMD_W   = $bits(lpr_pkg::cmd_t);
  localparam int ENTRY_W = CMD_W + 5 * CW + ERR_W;
  localparam int DW      = lpr_pkg::DIM_W;

  lpr_pkg::cfg_t cfg;

  lpr_pkg::cmd_t    f_cmd, q_cmd;
  logic [CW-1:0]    f_x, f_y, f_end, f_dmaj, f_dmin;
  logic [CW-1:0]    q_x, q_y, q_end, q_dmaj, q_dmin;
  logic [ERR_W-1:0] f_err, q_err;
  logic [ENTRY_W-1:0] push_entry, head_entry;
  logic             q_full, q_valid, q_pop, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= lpr_pkg::RESET_WIDTH;
      cfg.screen_height <= lpr_pkg::RESET_HEIGHT;
      cfg.pan_x         <= '0;
      cfg.pan_y         <= '0;
      cfg.row_stride    <= lpr_pkg::RESET_STRIDE;
      cfg.wide_pixels   <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        lpr_pkg::REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[DW-1:0];
        lpr_pkg::REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[DW-1:0];
        lpr_pkg::REG_PAN_X:         cfg.pan_x         <= cfg_data[DW-1:0];
        lpr_pkg::REG_PAN_Y:         cfg.pan_y         <= cfg_data[DW-1:0];
        lpr_pkg::REG_ROW_STRIDE:    cfg.row_stride    <= cfg_data;
        lpr_pkg::REG_WIDE_PIXELS:   cfg.wide_pixels   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lpr_front #(
    .COORD_BITS (COORD_BITS),
    .ERR_W      (ERR_W)
  ) u_front (
    .kind        (kind),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .red         (red),
    .green_level (green_level),
    .blue        (blue),
    .alpha       (alpha),
    .cmd         (f_cmd),
    .set_x       (f_x),
    .set_y       (f_y),
    .set_end     (f_end),
    .set_dmaj    (f_dmaj),
    .set_dmin    (f_dmin),
    .set_err     (f_err)
  );

  assign in_stall   = q_full;
  assign push       = in_valid && !q_full;
  assign push_entry = {f_cmd, f_x, f_y, f_end, f_dmaj, f_dmin, f_err};
  assign {q_cmd, q_x, q_y, q_end, q_dmaj, q_dmin, q_err} = head_entry;

  lpr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_entry)
  );

  lpr_back #(
    .COORD_BITS (COORD_BITS),
    .ERR_W      (ERR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_end       (q_end),
    .q_dmaj      (q_dmaj),
    .q_dmin      (q_dmin),
    .q_err       (q_err),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_offset (byte_offset),
    .pixel_word  (pixel_word),
    .visible     (visible),
    .is_last     (is_last)
  );

endmodule
